[rtl/core/naf_pkg.sv]
// ----------------------------------------------------------------------------
// Next free id allocator package
// Shared widths, limits and command codes for the id allocator.
// ----------------------------------------------------------------------------
package naf_pkg;

  // Default number of ids kept in the occupancy bitmap.
  localparam int NAF_NUM_IDS = 1024;

  // Width of an id field on the ports, and the number of ids it can carry.
  localparam int NAF_ID_W     = 10;
  localparam int NAF_ID_LIMIT = 1 << NAF_ID_W;

  // Width of one bitmap word, the span the search unit covers per step.
  localparam int NAF_WORD_W = 64;

  // Stream payload widths, padded to whole bytes.
  localparam int NAF_DATA_W = ((NAF_ID_W + 7) / 8) * 8;

  // Command codes carried on the input tuser.
  localparam logic NAF_CMD_ALLOC   = 1'b0;
  localparam logic NAF_CMD_RELEASE = 1'b1;

endpackage

[rtl/core/next_free_id_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Next free id allocator
// Grants the requested id or the lowest free id above it from a bitmap.
// ----------------------------------------------------------------------------
// A release is accepted, fetches its word and writes it back with its bit
// cleared; it gives no result. An allocate fetches and searches one bitmap
// word at a time upward from the start word, then offers the grant or a full
// answer until it is taken; one that starts past the last grantable id scans
// no word and goes straight to the full answer. One item at a time: a new
// request is taken only in S_IDLE, once the last result is taken or the
// release written. Reset clears the sequencer and the per-word valid flags,
// so every id reads as free right away; there is no clearing pass.
// ----------------------------------------------------------------------------
module next_free_id_allocator_unit #(
  parameter int NUM_IDS = naf_pkg::NAF_NUM_IDS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Request side.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [naf_pkg::NAF_DATA_W-1:0] s_tdata,  // [9:0] requested_id
  input  logic [0:0]                    s_tuser,  // [0] command
  // Result side.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [naf_pkg::NAF_DATA_W-1:0] m_tdata,  // [9:0] granted_id
  output logic [0:0]                    m_tuser   // [0] full_res
);

  import naf_pkg::*;

  // Only ids below both the store size and the reach of the id field are
  // ever granted; that count sizes the bitmap.
  localparam int LIM       = (NUM_IDS < NAF_ID_LIMIT) ? NUM_IDS : NAF_ID_LIMIT;
  localparam int WORD_W    = (LIM >= NAF_WORD_W) ? NAF_WORD_W : (1 << $clog2(LIM));
  localparam int OFF_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (LIM + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LAST_CNT  = LIM - (NUM_WORDS - 1) * WORD_W;

  // Bits of the last word that map to grantable ids.
  localparam logic [WORD_W-1:0] LAST_MASK = (LAST_CNT == WORD_W) ? {WORD_W{1'b1}} :
      (({{(WORD_W-1){1'b0}}, 1'b1} << LAST_CNT) - {{(WORD_W-1){1'b0}}, 1'b1});
  localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
  localparam logic [NAF_ID_W:0]   LIM_V     = (NAF_ID_W + 1)'(LIM);
  localparam logic [WORD_W-1:0]   ONE_BIT   = {{(WORD_W-1){1'b0}}, 1'b1};

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_CHECK = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  // Working registers for the item in flight.
  logic                 is_release, is_release_next;
  logic [ADDR_W-1:0]    addr, addr_next;
  logic [OFF_W-1:0]     start_off, start_off_next;
  logic [NAF_ID_W-1:0]  granted, granted_next;
  logic                 full_out, full_next;

  // A word that was never written reads as all free.
  logic [NUM_WORDS-1:0] row_valid;

  // Memory and search unit hookup.
  logic                 rd_en;
  logic [WORD_W-1:0]    rd_data;
  logic                 wr_en;
  logic [WORD_W-1:0]    wr_data;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    blocked;
  logic [WORD_W-1:0]    free_bits;
  logic                 found;
  logic [OFF_W-1:0]     found_off;

  // Request decode.
  logic                 cmd;
  logic [NAF_ID_W-1:0]  req_id;
  logic [NAF_ID_W-1:0]  start_id;

  assign cmd      = s_tuser[0];
  assign req_id   = s_tdata[NAF_ID_W-1:0];
  // Id zero is reserved as the full marker, so a search for it starts at one.
  assign start_id = (req_id == '0) ? NAF_ID_W'(1) : req_id;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = NAF_DATA_W'(granted);
  assign m_tuser  = full_out;

  assign rd_en = (state == S_FETCH);

  // The fetched word, with bits below the start point and bits past the
  // last grantable id treated as taken.
  assign word      = row_valid[addr] ? rd_data : '0;
  assign blocked   = ~({WORD_W{1'b1}} << start_off) |
                     ((addr == LAST_ADDR) ? ~LAST_MASK : '0);
  assign free_bits = ~word & ~blocked;

  naf_bitmap_ram #(
    .WORD_W (WORD_W),
    .DEPTH  (NUM_WORDS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data)
  );

  naf_find_free #(
    .WORD_W (WORD_W),
    .OFF_W  (OFF_W)
  ) u_find (
    .free_bits (free_bits),
    .found     (found),
    .offset    (found_off)
  );

  // Sequencer: fetch one word, search it, and either finish or move on to
  // the next word. A release uses the same fetch to do a read-modify-write.
  always_comb begin
    state_next      = state;
    is_release_next = is_release;
    addr_next       = addr;
    start_off_next  = start_off;
    granted_next    = granted;
    full_next       = full_out;
    wr_en           = 1'b0;
    wr_data         = word;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (cmd == NAF_CMD_RELEASE) begin
            // Releases of id zero or of ids past the store are dropped.
            is_release_next = 1'b1;
            addr_next       = ADDR_W'(req_id >> OFF_W);
            start_off_next  = req_id[OFF_W-1:0];
            if ((req_id != '0) && ({1'b0, req_id} < LIM_V)) begin
              state_next = S_FETCH;
            end
          end else begin
            is_release_next = 1'b0;
            addr_next       = ADDR_W'(start_id >> OFF_W);
            start_off_next  = start_id[OFF_W-1:0];
            if ({1'b0, start_id} < LIM_V) begin
              state_next = S_FETCH;
            end else begin
              // Nothing grantable at or above the request.
              granted_next = '0;
              full_next    = 1'b1;
              state_next   = S_OUT;
            end
          end
        end
      end
      S_FETCH: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (is_release) begin
          wr_en      = 1'b1;
          wr_data    = word & ~(ONE_BIT << start_off);
          state_next = S_IDLE;
        end else if (found) begin
          wr_en        = 1'b1;
          wr_data      = word | (ONE_BIT << found_off);
          granted_next = NAF_ID_W'({addr, found_off});
          full_next    = 1'b0;
          state_next   = S_OUT;
        end else if (addr == LAST_ADDR) begin
          granted_next = '0;
          full_next    = 1'b1;
          state_next   = S_OUT;
        end else begin
          addr_next      = addr + ADDR_W'(1);
          start_off_next = '0;
          state_next     = S_FETCH;
        end
      end
      S_OUT: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        row_valid[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_release <= is_release_next;
    addr       <= addr_next;
    start_off  <= start_off_next;
    granted    <= granted_next;
    full_out   <= full_next;
  end

  // A new request is never taken while a result is still on offer.
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("request side ready while a result is pending");

  // A granted id is never the reserved zero and lies inside the store.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tuser[0]) |->
      ((m_tdata[NAF_ID_W-1:0] != '0) && ({1'b0, m_tdata[NAF_ID_W-1:0]} < LIM_V)))
    else $error("granted id out of range");

  // The full answer always carries id zero.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser[0]) |-> (m_tdata[NAF_ID_W-1:0] == '0))
    else $error("full result with nonzero id");

  // A release never produces a result in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready && (s_tuser[0] == NAF_CMD_RELEASE)) |=> !m_tvalid)
    else $error("release produced a result");

endmodule

[rtl/core/naf_bitmap_ram.sv]
// ----------------------------------------------------------------------------
// Occupancy bitmap memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module naf_bitmap_ram #(
  parameter int WORD_W = 64,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/naf_find_free.sv]
// ----------------------------------------------------------------------------
// Free bit search unit
// Finds the lowest set bit of a candidate vector and returns its position.
// ----------------------------------------------------------------------------
module naf_find_free #(
  parameter int WORD_W = 64,
  parameter int OFF_W  = 6
) (
  input  logic [WORD_W-1:0] free_bits,
  output logic              found,
  output logic [OFF_W-1:0]  offset
);

  logic [WORD_W-1:0] lowest;

  // Two's complement trick isolates the lowest set bit as a one-hot word.
  assign lowest = free_bits & (~free_bits + {{(WORD_W-1){1'b0}}, 1'b1});
  assign found  = |free_bits;

  // One-hot to binary: each output bit ORs the positions that carry it.
  always_comb begin
    offset = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        offset = offset | OFF_W'(i);
      end
    end
  end

endmodule

[tb/sv/next_free_id_allocator_unit_tb.sv]
// ----------------------------------------------------------------------------
// Next free id allocator testbench
// Sends allocate and release requests through the stream ports. A scoreboard
// keeps its own occupancy map and predicts each grant or full answer. The
// traffic runs through several phases of sender gaps and receiver stalls,
// plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module next_free_id_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import naf_pkg::*;

  // Ids that can ever be granted: inside the bitmap and inside the id field.
  localparam int GRANT_LIMIT    = (NAF_NUM_IDS < NAF_ID_LIMIT) ? NAF_NUM_IDS : NAF_ID_LIMIT;
  localparam int HOLDOFF_CYCLES = 400;
  // The worst allocate scans every bitmap word.
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_SHOWN      = 10;

  typedef struct {
    logic                cmd;
    logic [NAF_ID_W-1:0] id;
  } id_request_t;

  typedef struct {
    logic [NAF_ID_W-1:0] id;
    logic                full;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [NAF_DATA_W-1:0] s_tdata = '0;   // [9:0] requested_id
  logic [0:0]            s_tuser = '0;   // [0] command
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [NAF_DATA_W-1:0] m_tdata;        // [9:0] granted_id
  logic [0:0]            m_tuser;        // [0] full_res

  // Requests waiting to be driven, and grants the scoreboard is waiting on.
  id_request_t request_queue[$];
  grant_t      grant_queue[$];

  // Scoreboard copy of the occupancy bitmap; every id is free after reset.
  bit id_busy [GRANT_LIMIT];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic holdoff_go = 1'b0;
  logic hold_rx    = 1'b0;

  int mismatches  = 0;
  int n_allocs    = 0;
  int n_full      = 0;
  int n_releases  = 0;

  next_free_id_allocator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Updates the occupancy map for one accepted request. An allocate searches
  // upward from the wanted id (id zero is reserved, so the search starts at
  // one) and queues either the granted id or a full answer. A release clears
  // the id unless it is zero or out of range, and queues nothing.
  function automatic void predict_grant(logic cmd, logic [NAF_ID_W-1:0] req);
    int     id;
    grant_t g;
    if (cmd == NAF_CMD_RELEASE) begin
      n_releases++;
      if (req != 0 && int'(req) < GRANT_LIMIT) id_busy[req] = 1'b0;
      return;
    end
    n_allocs++;
    id = (req == 0) ? 1 : int'(req);
    while (id < GRANT_LIMIT && id_busy[id]) id++;
    if (id >= GRANT_LIMIT) begin
      // Full leaves the map alone and reports id zero.
      g.id   = '0;
      g.full = 1'b1;
      n_full++;
    end else begin
      id_busy[id] = 1'b1;
      g.id        = id[NAF_ID_W-1:0];
      g.full      = 1'b0;
    end
    grant_queue.push_back(g);
  endfunction

  // Request driver. The prediction is made at the edge where an item is
  // accepted, so it always sees the requests in the order the block does.
  // The valid and payload only change once the current item is gone.
  always @(posedge clk) begin : request_driver
    id_request_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_grant(s_tuser[0], s_tdata[NAF_ID_W-1:0]);
      if (!s_tvalid || s_tready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(NAF_DATA_W - NAF_ID_W){1'b0}}, nxt.id};
          s_tuser  <= nxt.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Ready is randomized per cycle and forced low during the
  // long hold-off; each accepted result is checked against the oldest grant.
  always @(posedge clk) begin : result_monitor
    grant_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        if (grant_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%t: result with nothing expected: id %0d full %0b",
                     $realtime, m_tdata[NAF_ID_W-1:0], m_tuser[0]);
        end else begin
          want = grant_queue.pop_front();
          if (m_tdata[NAF_ID_W-1:0] !== want.id || m_tuser[0] !== want.full) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%t: grant mismatch: expected id %0d full %0b, got id %0d full %0b",
                       $realtime, want.id, want.full, m_tdata[NAF_ID_W-1:0], m_tuser[0]);
          end
        end
      end
    end
  end

  // Long receiver hold-off, counted here so that the sender keeps offering
  // requests while results back up and the block stops taking input.
  initial begin : rx_holdoff
    wait (holdoff_go);
    hold_rx <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic push_req(logic cmd, int id);
    id_request_t r;
    r.cmd = cmd;
    r.id  = id[NAF_ID_W-1:0];
    request_queue.push_back(r);
  endtask

  // Bursts of traffic inside a narrow window of ids, so that allocations
  // collide, searches run over occupied stretches and the top of the id space
  // fills up until requests answer full. A small share is unaligned noise.
  task automatic load_random(int count);
    int base;
    int span;
    int roll;
    int left;
    int id;
    left = count;
    while (left > 0) begin
      case ($urandom_range(3))
        0:       base = $urandom_range(960, 1023);
        1:       base = $urandom_range(1, 64);
        default: base = $urandom_range(1, 1023);
      endcase
      span = $urandom_range(8, 24);
      for (int k = 0; k < span && left > 0; k++) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          push_req(1'($urandom_range(1)), $urandom_range(0, 1023));
        end else begin
          id = base + $urandom_range(0, 31);
          if (id > 1023) id = 1023;
          push_req((roll < 70) ? NAF_CMD_ALLOC : NAF_CMD_RELEASE, id);
        end
        left--;
      end
    end
  endtask

  // Waits at falling edges until every request has been taken and every
  // predicted result has come back.
  task automatic wait_drained();
    while (request_queue.size() != 0 || s_tvalid || grant_queue.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    load_random(count);
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: reserved id zero, both ends of the id range, a full
    // answer at the top, releases of free and out-of-range ids, and the
    // search skipping over taken ids.
    push_req(NAF_CMD_ALLOC,   0);     // searches from one, grants 1
    push_req(NAF_CMD_ALLOC,   1);     // 1 taken, grants 2
    push_req(NAF_CMD_ALLOC,   1023);  // top id
    push_req(NAF_CMD_ALLOC,   1023);  // nothing above, answers full
    push_req(NAF_CMD_RELEASE, 0);     // ignored
    push_req(NAF_CMD_RELEASE, 1023);
    push_req(NAF_CMD_RELEASE, 1023);  // already free
    push_req(NAF_CMD_ALLOC,   1023);  // granted again
    push_req(NAF_CMD_ALLOC,   512);
    push_req(NAF_CMD_ALLOC,   512);   // grants 513
    push_req(NAF_CMD_ALLOC,   0);     // grants 3
    push_req(NAF_CMD_RELEASE, 2);
    push_req(NAF_CMD_ALLOC,   1);     // finds the hole at 2
    push_req(NAF_CMD_ALLOC,   1022);
    push_req(NAF_CMD_ALLOC,   1021);
    push_req(NAF_CMD_ALLOC,   1021);  // 1021..1023 taken, answers full
    push_req(NAF_CMD_RELEASE, 5);     // never taken
    push_req(NAF_CMD_ALLOC,   'h2AA);
    push_req(NAF_CMD_ALLOC,   'h155);
    push_req(NAF_CMD_RELEASE, 'h2AA);
    push_req(NAF_CMD_ALLOC,   'h2A9); // grants 0x2A9
    push_req(NAF_CMD_ALLOC,   'h2A9); // 0x2AA is free again
    wait_drained();

    // Random traffic under each mix of sender gaps and receiver stalls.
    run_phase(115, 0,  0);
    run_phase(115, 71, 0);
    run_phase(115, 0,  71);
    run_phase(115, 34, 34);

    // Back pressure: results pile up behind a long receiver hold-off while
    // the sender offers requests every cycle.
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_go     = 1'b1;
    @(negedge clk);
    load_random(60);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d allocate requests, %0d of them answered full, and %0d releases,",
             n_allocs, n_full, n_releases);
    $display("over five stall mixes including a %0d-cycle receiver hold-off.",
             HOLDOFF_CYCLES);
    if (mismatches == 0 && grant_queue.size() == 0) begin
      $display("next_free_id_allocator_unit_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatches, grant_queue.size());
      $display("next_free_id_allocator_unit_tb: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #5ms;
    $display("Timeout with %0d requests queued and %0d results expected",
             request_queue.size(), grant_queue.size());
    $display("next_free_id_allocator_unit_tb: FAIL");
    $finish;
  end

endmodule

[next_free_id_allocator_unit.f]
rtl/core/naf_pkg.sv
rtl/core/naf_bitmap_ram.sv
rtl/core/naf_find_free.sv
rtl/core/next_free_id_allocator_unit.sv
tb/sv/next_free_id_allocator_unit_tb.sv
